// ----- rtl/csg_pkg.sv -----
// Shared types, constants and arithmetic helpers of the circle/spiral setpoint generator.
package csg_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_PERIOD   = 3'd1;
  localparam logic [2:0] REG_RADIUS   = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_DESCENT  = 3'd5;

  localparam logic [19:0] MIN_PERIOD_MS     = 20'd1000;
  localparam logic [19:0] DEFAULT_PERIOD_MS = 20'd100000;
  localparam logic [9:0]  US_PER_MS         = 10'd1000;
  localparam logic [31:0] US_PER_S          = 32'd1000000;
  // 2*pi in Q32 times 10^6, numerator of the angular rate division
  localparam logic [54:0] W_NUM             = 55'd26986075409000000;
  localparam logic [31:0] HALF_PI_Q30       = 32'd1686629713;
  localparam logic [30:0] ONE_Q30           = 31'h4000_0000;
  localparam logic [29:0] EIGHTH_TURN       = 30'h2000_0000;
  localparam logic [40:0] MAG_CAP           = 41'h100_0000_0000;

  // Series terms: first five refine sine, last five cosine
  localparam int TERMS    = 10;
  localparam int TS_TERMS = 5;
  localparam int PRODS    = 8;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DEL, ST_DEL_WT, ST_DELW, ST_DTU, ST_DTU_WT, ST_DTUW,
    ST_DW, ST_DW_WT, ST_DWW, ST_MX, ST_MXW, ST_MX2, ST_MX2W,
    ST_TM, ST_TMW, ST_TR, ST_TRW, ST_TC, ST_MS, ST_MSW,
    ST_M1, ST_M1W, ST_M2, ST_M2W, ST_M3, ST_M3W, ST_PM, ST_PMW,
    ST_ZM, ST_ZD, ST_ZD_WT, ST_ZDW, ST_QM, ST_QMW,
    ST_VM, ST_VD, ST_VD_WT, ST_VDW, ST_PUB
  } state_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_ACC, OP_DEL, OP_DELW, OP_DTU, OP_DTUW, OP_DW, OP_DWW,
    OP_MX, OP_MXW, OP_MX2, OP_MX2W, OP_TM, OP_TMW, OP_TR, OP_TRW, OP_TC,
    OP_MS, OP_MSW, OP_M1, OP_M1W, OP_M2, OP_M2W, OP_M3, OP_M3W,
    OP_PM, OP_PMW, OP_ZM, OP_ZD, OP_ZDW, OP_QM, OP_QMW,
    OP_VM, OP_VD, OP_VDW, OP_PUB
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic mode;
  } sts_t;

  function automatic logic [31:0] term_recip(input logic [3:0] idx);
    logic [31:0] r;
    case (idx)
      4'd0:    r = 32'd39045157;
      4'd1:    r = 32'd59652323;
      4'd2:    r = 32'd102261126;
      4'd3:    r = 32'd214748364;
      4'd4:    r = 32'd715827882;
      4'd5:    r = 32'd47721858;
      4'd6:    r = 32'd76695844;
      4'd7:    r = 32'd143165576;
      4'd8:    r = 32'd357913941;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] term_div(input logic [3:0] idx);
    logic [6:0] k;
    case (idx)
      4'd0:    k = 7'd110;
      4'd1:    k = 7'd72;
      4'd2:    k = 7'd42;
      4'd3:    k = 7'd20;
      4'd4:    k = 7'd6;
      4'd5:    k = 7'd90;
      4'd6:    k = 7'd56;
      4'd7:    k = 7'd30;
      4'd8:    k = 7'd12;
      default: k = 7'd2;
    endcase
    return k;
  endfunction

  function automatic logic [40:0] clamp_mag(input logic [44:0] v);
    return (v > 45'(MAG_CAP)) ? MAG_CAP : v[40:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/circle_spiral_setpoint_generator.sv -----
// Circle/spiral setpoint generator: one setpoint with derivatives per tick transaction.
// Each accepted tick advances elapsed time by dt_us and produces one result of ten
// saturated Q16.16 fields. Work on a tick runs through one shared radix-2 divider (one
// quotient bit per cycle) and one multiplier. Every tick takes 48-, 32- and 55-bit
// quotients from the divider and evaluates a ten-term sine/cosine series, and spiral
// mode adds a 62- and a 51-bit quotient. A new tick is taken once the previous result
// sits in the output register, even if it has not yet been taken. Configuration writes
// take effect at once and belong between transactions.
module circle_spiral_setpoint_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        dt_us,
  input  logic               new_position,
  input  logic signed [31:0] measured_z,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic signed [31:0] acc_x,
  output logic signed [31:0] acc_y,
  output logic signed [31:0] jerk_x,
  output logic signed [31:0] jerk_y
);
  import csg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  csg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .dt_us        (dt_us),
    .new_position (new_position),
    .measured_z   (measured_z),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .vel_z        (vel_z),
    .acc_x        (acc_x),
    .acc_y        (acc_y),
    .jerk_x       (jerk_x),
    .jerk_y       (jerk_y)
  );
endmodule

// ----- rtl/csg_div.sv -----
// Radix-2 restoring divider shared by all quotient and remainder steps.
module csg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] divisor,
  input  logic [33:0] rem_init,
  input  logic [63:0] dividend,
  input  logic [6:0]  nbits,
  output logic [63:0] quot,
  output logic [33:0] rem,
  output logic        done
);
  logic        busy;
  logic [6:0]  cnt;
  logic [33:0] dv;
  logic [63:0] d;
  logic [34:0] trial;
  logic [34:0] diff;
  logic        ge;

  assign trial = {rem, d[63]};
  assign diff  = trial - {1'b0, dv};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      d    <= dividend;
      quot <= '0;
      dv   <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[33:0] : trial[33:0];
      d    <= {d[62:0], 1'b0};
      quot <= {quot[62:0], ge};
    end
  end
endmodule

// ----- rtl/csg_dp.sv -----
// Datapath: configuration, time state, shared multiplier and divider, result registers.
module csg_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [19:0]        dt_us,
  input  logic               new_position,
  input  logic signed [31:0] measured_z,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               out_ready,
  input  csg_pkg::cmd_t      cmd,
  output csg_pkg::sts_t      sts,
  output logic               out_valid,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic signed [31:0] acc_x,
  output logic signed [31:0] acc_y,
  output logic signed [31:0] jerk_x,
  output logic signed [31:0] jerk_y
);
  import csg_pkg::*;

  logic               mode;
  logic [19:0]        period_ms;
  logic signed [31:0] radius, center_x, center_y, descent;
  logic [47:0]        elapsed;
  logic signed [31:0] held_z;

  logic [29:0] tp, phase;
  logic [28:0] qel;
  logic [31:0] turn, zf;
  logic [30:0] w, x, ts, tc;
  logic [29:0] x2, vt, q0;
  logic [30:0] sn_mag, cs_mag;
  logic        sn_neg, cs_neg;
  logic [40:0] m1, m2, m3;
  logic signed [31:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, r9;

  logic [40:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] plo;
  logic [40:0] phi;
  logic [72:0] full;
  logic [40:0] c28, c30;

  logic [19:0] per_eff;
  logic [31:0] rm, dm;
  logic        rneg, dneg;
  logic [29:0] rem30, a_red;
  logic        swap;
  logic [1:0]  quad;
  logic [30:0] term_t;
  logic [36:0] prodk, kdiff;
  logic [29:0] qq;
  logic [30:0] s1, sw_s, sw_c;
  logic [40:0] pm_mag;
  logic [31:0] pm_trig;
  logic        pm_tneg;
  logic signed [63:0] p, zm, vz;

  logic        div_start, div_done;
  logic [33:0] div_divisor, div_rem_init, div_rem;
  logic [63:0] div_dividend, div_quot;
  logic [6:0]  div_nbits;

  assign per_eff = (period_ms < MIN_PERIOD_MS) ? DEFAULT_PERIOD_MS : period_ms;
  assign rneg    = radius[31];
  assign rm      = rneg ? (~radius + 32'd1) : radius;
  assign dneg    = descent[31];
  assign dm      = dneg ? (~descent + 32'd1) : descent;

  // Octant reduction of the turn fraction
  assign quad  = turn[31:30];
  assign rem30 = turn[29:0];
  assign swap  = rem30 > EIGHTH_TURN;
  assign a_red = swap ? 30'(ONE_Q30 - 31'(rem30)) : rem30;

  assign term_t = (cmd.idx < 4'(TS_TERMS)) ? ts : tc;

  always_comb begin
    pm_mag  = 41'(rm);
    pm_trig = 32'(sn_mag);
    pm_tneg = sn_neg;
    case (cmd.idx)
      4'd0:    begin pm_mag = 41'(rm); pm_trig = 32'(sn_mag); pm_tneg = sn_neg; end
      4'd1:    begin pm_mag = 41'(rm); pm_trig = 32'(cs_mag); pm_tneg = cs_neg; end
      4'd2:    begin pm_mag = m1;      pm_trig = 32'(cs_mag); pm_tneg = cs_neg; end
      4'd3:    begin pm_mag = m1;      pm_trig = 32'(sn_mag); pm_tneg = sn_neg; end
      4'd4:    begin pm_mag = m2;      pm_trig = 32'(sn_mag); pm_tneg = sn_neg; end
      4'd5:    begin pm_mag = m2;      pm_trig = 32'(cs_mag); pm_tneg = cs_neg; end
      4'd6:    begin pm_mag = m3;      pm_trig = 32'(cs_mag); pm_tneg = cs_neg; end
      default: begin pm_mag = m3;      pm_trig = 32'(sn_mag); pm_tneg = sn_neg; end
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MX:   begin mul_a = 41'(a_red); mul_b = HALF_PI_Q30;         end
      OP_MX2:  begin mul_a = 41'(x);     mul_b = 32'(x);              end
      OP_TM:   begin mul_a = 41'(x2);    mul_b = 32'(term_t);         end
      OP_TR:   begin mul_a = 41'(vt);    mul_b = term_recip(cmd.idx); end
      OP_MS:   begin mul_a = 41'(x);     mul_b = 32'(ts);             end
      OP_M1:   begin mul_a = 41'(rm);    mul_b = 32'(w);              end
      OP_M2:   begin mul_a = m1;         mul_b = 32'(w);              end
      OP_M3:   begin mul_a = m2;         mul_b = 32'(w);              end
      OP_PM:   begin mul_a = pm_mag;     mul_b = pm_trig;             end
      OP_ZM:   begin mul_a = 41'(dm);    mul_b = 32'(phase);          end
      OP_QM:   begin mul_a = 41'(dm);    mul_b = 32'(qel);            end
      OP_VM:   begin mul_a = 41'(dm);    mul_b = US_PER_S;            end
      default: begin mul_a = '0;         mul_b = '0;                  end
    endcase
  end

  always_ff @(posedge clk) begin
    plo <= 64'(mul_a[31:0]) * 64'(mul_b);
    phi <= 41'(mul_a[40:32]) * 41'(mul_b);
  end

  assign full = {phi, 32'b0} + 73'(plo);
  assign c28  = clamp_mag(full[72:28]);
  assign c30  = clamp_mag(45'(full[72:30]));

  // Exact floor of v/k from the reciprocal estimate
  assign prodk = 37'(q0) * 37'(term_div(cmd.idx));
  assign kdiff = 37'(vt) - prodk;
  assign qq    = q0 + 30'(kdiff >= 37'(term_div(cmd.idx)));

  assign s1   = full[60:30];
  assign sw_s = swap ? tc : s1;
  assign sw_c = swap ? s1 : tc;

  assign p  = (rneg ^ pm_tneg) ? -$signed(64'(c30)) : $signed(64'(c30));
  assign zm = $signed(64'(full[60:0]) + 64'(zf));
  assign vz = $signed(64'(div_quot[31:0]));

  always_comb begin
    div_start    = 1'b0;
    div_divisor  = {4'b0, tp};
    div_rem_init = '0;
    div_dividend = '0;
    div_nbits    = 7'd48;
    case (cmd.op)
      OP_DEL: begin
        div_start    = 1'b1;
        div_dividend = {elapsed, 16'b0};
        div_nbits    = 7'd48;
      end
      OP_DTU: begin
        div_start    = 1'b1;
        div_rem_init = 34'(phase);
        div_nbits    = 7'd32;
      end
      OP_DW: begin
        div_start    = 1'b1;
        div_divisor  = {tp, 4'b0};
        div_dividend = {W_NUM, 9'b0};
        div_nbits    = 7'd55;
      end
      OP_ZD: begin
        div_start    = 1'b1;
        div_dividend = {full[61:0], 2'b0};
        div_nbits    = 7'd62;
      end
      OP_VD: begin
        div_start    = 1'b1;
        div_dividend = {full[50:0], 13'b0};
        div_nbits    = 7'd51;
      end
      default: div_start = 1'b0;
    endcase
  end

  csg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_divisor),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .nbits    (div_nbits),
    .quot     (div_quot),
    .rem      (div_rem),
    .done     (div_done)
  );

  // Configuration and time state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      period_ms <= '0;
      radius    <= '0;
      center_x  <= '0;
      center_y  <= '0;
      descent   <= '0;
      elapsed   <= '0;
      held_z    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MODE:     mode      <= cfg_data[0];
          REG_PERIOD:   period_ms <= cfg_data[19:0];
          REG_RADIUS:   radius    <= cfg_data;
          REG_CENTER_X: center_x  <= cfg_data;
          REG_CENTER_Y: center_y  <= cfg_data;
          REG_DESCENT:  descent   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_ACC) begin
        elapsed <= elapsed + 48'(dt_us);
        if (new_position) held_z <= measured_z;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACC:  tp <= 30'(per_eff * US_PER_MS);
      OP_DEL:  begin r2 <= held_z; r5 <= '0; end
      OP_DELW: begin qel <= div_quot[28:0]; phase <= div_rem[29:0]; end
      OP_DTUW: turn <= div_quot[31:0];
      OP_DWW:  w <= div_quot[30:0];
      OP_MXW:  x <= full[60:30];
      OP_MX2W: begin x2 <= full[59:30]; ts <= ONE_Q30; tc <= ONE_Q30; end
      OP_TMW:  vt <= full[59:30];
      OP_TRW:  q0 <= full[61:32];
      OP_TC: begin
        if (cmd.idx < 4'(TS_TERMS)) ts <= ONE_Q30 - 31'(qq);
        else                        tc <= ONE_Q30 - 31'(qq);
      end
      OP_MSW: begin
        case (quad)
          2'd0: begin sn_mag <= sw_s; sn_neg <= 1'b0; cs_mag <= sw_c; cs_neg <= 1'b0; end
          2'd1: begin sn_mag <= sw_c; sn_neg <= 1'b0; cs_mag <= sw_s; cs_neg <= 1'b1; end
          2'd2: begin sn_mag <= sw_s; sn_neg <= 1'b1; cs_mag <= sw_c; cs_neg <= 1'b1; end
          default: begin
            sn_mag <= sw_c; sn_neg <= 1'b1; cs_mag <= sw_s; cs_neg <= 1'b0;
          end
        endcase
      end
      OP_M1W: m1 <= c28;
      OP_M2W: m2 <= c28;
      OP_M3W: m3 <= c28;
      OP_PMW: begin
        case (cmd.idx)
          4'd0: r0 <= sat32((mode ? 64'sd0 : 64'(center_x)) + p);
          4'd1: r1 <= sat32((mode ? 64'(radius) : 64'(center_y)) - p);
          4'd2: r3 <= sat32(p);
          4'd3: r4 <= sat32(p);
          4'd4: r6 <= sat32(-p);
          4'd5: r7 <= sat32(p);
          4'd6: r8 <= sat32(-p);
          default: r9 <= sat32(-p);
        endcase
      end
      OP_ZDW: zf <= div_quot[31:0];
      OP_QMW: r2 <= sat32(dneg ? -zm : zm);
      OP_VDW: r5 <= sat32(dneg ? -vz : vz);
      default: ;
    endcase
  end

  // Output stage: holds the finished transaction while the next one computes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PUB && sts.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUB && sts.out_free) begin
      pos_x  <= r0;
      pos_y  <= r1;
      pos_z  <= r2;
      vel_x  <= r3;
      vel_y  <= r4;
      vel_z  <= r5;
      acc_x  <= r6;
      acc_y  <= r7;
      jerk_x <= r8;
      jerk_y <= r9;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;
  assign sts.mode     = mode;
endmodule

// ----- rtl/csg_ctrl.sv -----
// Controller: sequences the datapath operations for one transaction.
module csg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  csg_pkg::sts_t sts,
  output logic          in_ready,
  output csg_pkg::cmd_t cmd
);
  import csg_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (state == ST_TC) begin
        cnt <= (cnt == 4'(TERMS - 1)) ? 4'd0 : cnt + 4'd1;
      end else if (state == ST_PMW) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DEL;
      ST_DEL:    state_next = ST_DEL_WT;
      ST_DEL_WT: if (sts.div_done) state_next = ST_DELW;
      ST_DELW:   state_next = ST_DTU;
      ST_DTU:    state_next = ST_DTU_WT;
      ST_DTU_WT: if (sts.div_done) state_next = ST_DTUW;
      ST_DTUW:   state_next = ST_DW;
      ST_DW:     state_next = ST_DW_WT;
      ST_DW_WT:  if (sts.div_done) state_next = ST_DWW;
      ST_DWW:    state_next = ST_MX;
      ST_MX:     state_next = ST_MXW;
      ST_MXW:    state_next = ST_MX2;
      ST_MX2:    state_next = ST_MX2W;
      ST_MX2W:   state_next = ST_TM;
      ST_TM:     state_next = ST_TMW;
      ST_TMW:    state_next = ST_TR;
      ST_TR:     state_next = ST_TRW;
      ST_TRW:    state_next = ST_TC;
      ST_TC:     state_next = (cnt == 4'(TERMS - 1)) ? ST_MS : ST_TM;
      ST_MS:     state_next = ST_MSW;
      ST_MSW:    state_next = ST_M1;
      ST_M1:     state_next = ST_M1W;
      ST_M1W:    state_next = ST_M2;
      ST_M2:     state_next = ST_M2W;
      ST_M2W:    state_next = ST_M3;
      ST_M3:     state_next = ST_M3W;
      ST_M3W:    state_next = ST_PM;
      ST_PM:     state_next = ST_PMW;
      ST_PMW: begin
        if (cnt != 4'(PRODS - 1)) state_next = ST_PM;
        else state_next = sts.mode ? ST_ZM : ST_PUB;
      end
      ST_ZM:     state_next = ST_ZD;
      ST_ZD:     state_next = ST_ZD_WT;
      ST_ZD_WT:  if (sts.div_done) state_next = ST_ZDW;
      ST_ZDW:    state_next = ST_QM;
      ST_QM:     state_next = ST_QMW;
      ST_QMW:    state_next = ST_VM;
      ST_VM:     state_next = ST_VD;
      ST_VD:     state_next = ST_VD_WT;
      ST_VD_WT:  if (sts.div_done) state_next = ST_VDW;
      ST_VDW:    state_next = ST_PUB;
      ST_PUB:    if (sts.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.idx  = cnt;
    cmd.op   = OP_NOP;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_ACC : OP_NOP;
      end
      ST_DEL:  cmd.op = OP_DEL;
      ST_DELW: cmd.op = OP_DELW;
      ST_DTU:  cmd.op = OP_DTU;
      ST_DTUW: cmd.op = OP_DTUW;
      ST_DW:   cmd.op = OP_DW;
      ST_DWW:  cmd.op = OP_DWW;
      ST_MX:   cmd.op = OP_MX;
      ST_MXW:  cmd.op = OP_MXW;
      ST_MX2:  cmd.op = OP_MX2;
      ST_MX2W: cmd.op = OP_MX2W;
      ST_TM:   cmd.op = OP_TM;
      ST_TMW:  cmd.op = OP_TMW;
      ST_TR:   cmd.op = OP_TR;
      ST_TRW:  cmd.op = OP_TRW;
      ST_TC:   cmd.op = OP_TC;
      ST_MS:   cmd.op = OP_MS;
      ST_MSW:  cmd.op = OP_MSW;
      ST_M1:   cmd.op = OP_M1;
      ST_M1W:  cmd.op = OP_M1W;
      ST_M2:   cmd.op = OP_M2;
      ST_M2W:  cmd.op = OP_M2W;
      ST_M3:   cmd.op = OP_M3;
      ST_M3W:  cmd.op = OP_M3W;
      ST_PM:   cmd.op = OP_PM;
      ST_PMW:  cmd.op = OP_PMW;
      ST_ZM:   cmd.op = OP_ZM;
      ST_ZD:   cmd.op = OP_ZD;
      ST_ZDW:  cmd.op = OP_ZDW;
      ST_QM:   cmd.op = OP_QM;
      ST_QMW:  cmd.op = OP_QMW;
      ST_VM:   cmd.op = OP_VM;
      ST_VD:   cmd.op = OP_VD;
      ST_VDW:  cmd.op = OP_VDW;
      ST_PUB:  cmd.op = OP_PUB;
      ST_DEL_WT, ST_DTU_WT, ST_DW_WT, ST_ZD_WT, ST_VD_WT: cmd.op = OP_NOP;
      default: cmd.op = OP_NOP;
    endcase
  end
endmodule

// ----- rtl/csg_checker.sv -----
// Port-level checks of the setpoint generator and their attachment to the top level.
module csg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] jerk_y
);
  a_reset_state: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("reset did not clear output and open input");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no transaction in work");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(jerk_y))
    else $error("stalled result changed or dropped");
endmodule

bind circle_spiral_setpoint_generator csg_checker u_csg_checker (.*);

// ----- tb/sv/circle_spiral_setpoint_generator_tb.sv -----
// Testbench for the circle/spiral setpoint generator: queued ticks against a fixed-point model.
`timescale 1ns / 1ps

module circle_spiral_setpoint_generator_tb;
  import csg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [19:0]        dt;
    logic               fresh;
    logic signed [31:0] z;
  } tick_t;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz, ax, ay, jx, jy;
  } setpoint_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [19:0]        dt_us = '0;
  logic               new_position = 1'b0;
  logic signed [31:0] measured_z = '0;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = REG_MODE;
  logic [31:0]        cfg_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, jerk_x, jerk_y;

  circle_spiral_setpoint_generator dut (.*);

  always #1 clk = ~clk;

  // Configuration and state shadow
  logic        sh_mode;
  logic [19:0] sh_period;
  longint      sh_radius, sh_cx, sh_cy, sh_descent;
  logic [47:0] sh_elapsed;
  longint      sh_held_z;

  tick_t     tick_q[$];
  setpoint_t setpoint_q[$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  int        in_gap = 0, out_gap = 0;

  function automatic logic [63:0] scale_mag(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    return (p > 128'd1099511627776) ? 64'd1099511627776 : p[63:0];
  endfunction

  function automatic longint trig_mul(logic [63:0] mag, bit neg, longint trig);
    logic [63:0] m;
    m = scale_mag(mag, (trig < 0) ? -trig : trig, 30);
    return (neg != (trig < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void sin_cos_q30(logic [31:0] turn, output longint sn, output longint cs);
    logic [63:0] one, rem, a, x, x2, ts, tc, s, c, t;
    bit swap;
    int divs[10];
    divs = '{110, 72, 42, 20, 6, 90, 56, 30, 12, 2};
    one = 64'd1 << 30;
    rem = {34'd0, turn[29:0]};
    swap = rem > (64'd1 << 29);
    a = swap ? one - rem : rem;
    x = (a * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    ts = one;
    tc = one;
    for (int i = 0; i < 5; i++) ts = one - ((x2 * ts) >> 30) / divs[i];
    for (int i = 5; i < 10; i++) tc = one - ((x2 * tc) >> 30) / divs[i];
    s = (x * ts) >> 30;
    c = tc;
    if (swap) begin
      t = s; s = c; c = t;
    end
    case (turn[31:30])
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // Advance the shadow state by one tick and form its setpoint
  function automatic setpoint_t next_setpoint(tick_t tk);
    setpoint_t r;
    logic [63:0] tp, phase, w, rm, m1, m2, m3, dm, zm;
    longint sn, cs, rs, rc, zv, vz;
    bit rneg, dneg;
    tp = ((sh_period < 20'd1000) ? 64'd100000 : 64'(sh_period)) * 64'd1000;
    sh_elapsed = sh_elapsed + 48'(tk.dt);
    if (tk.fresh) sh_held_z = tk.z;
    phase = 64'(sh_elapsed) % tp;
    sin_cos_q30(32'((phase << 32) / tp), sn, cs);
    w = (64'd26986075409 * 64'd1000000) / (tp << 4);
    rneg = sh_radius < 0;
    rm = rneg ? -sh_radius : sh_radius;
    m1 = scale_mag(rm, w, 28);
    m2 = scale_mag(m1, w, 28);
    m3 = scale_mag(m2, w, 28);
    rs = trig_mul(rm, rneg, sn);
    rc = trig_mul(rm, rneg, cs);
    if (sh_mode) begin
      dneg = sh_descent < 0;
      dm = dneg ? -sh_descent : sh_descent;
      zm = dm * (64'(sh_elapsed) / tp) + (dm * phase) / tp;
      zv = dneg ? -longint'(zm) : longint'(zm);
      zm = (dm * 64'd1000000) / tp;
      vz = dneg ? -longint'(zm) : longint'(zm);
      r.px = clip32(rs);
      r.py = clip32(sh_radius - rc);
    end else begin
      zv = sh_held_z;
      vz = 0;
      r.px = clip32(sh_cx + rs);
      r.py = clip32(sh_cy - rc);
    end
    r.pz = clip32(zv);
    r.vz = clip32(vz);
    r.vx = clip32(trig_mul(m1, rneg, cs));
    r.vy = clip32(trig_mul(m1, rneg, sn));
    r.ax = clip32(-trig_mul(m2, rneg, sn));
    r.ay = clip32(trig_mul(m2, rneg, cs));
    r.jx = clip32(-trig_mul(m3, rneg, cs));
    r.jy = clip32(-trig_mul(m3, rneg, sn));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Driver: present queued ticks, predict on each accepted transaction
  always @(posedge clk) begin
    tick_t tk;
    if (!rst) begin
      if (in_valid && in_ready)
        setpoint_q.push_back(next_setpoint('{dt_us, new_position, measured_z}));
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tk = tick_q.pop_front();
          in_valid <= 1'b1;
          dt_us <= tk.dt;
          new_position <= tk.fresh;
          measured_z <= tk.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    setpoint_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (setpoint_q.size() == 0) begin
          report_mismatch("unexpected result", pos_x, 32'd0);
        end else begin
          e = setpoint_q.pop_front();
          check_field("pos_x", pos_x, e.px);
          check_field("pos_y", pos_y, e.py);
          check_field("pos_z", pos_z, e.pz);
          check_field("vel_x", vel_x, e.vx);
          check_field("vel_y", vel_y, e.vy);
          check_field("vel_z", vel_z, e.vz);
          check_field("acc_x", acc_x, e.ax);
          check_field("acc_y", acc_y, e.ay);
          check_field("jerk_x", jerk_x, e.jx);
          check_field("jerk_y", jerk_y, e.jy);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL circle_spiral_setpoint_generator");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODE:     sh_mode = val[0];
      REG_PERIOD:   sh_period = val[19:0];
      REG_RADIUS:   sh_radius = longint'(signed'(val));
      REG_CENTER_X: sh_cx = longint'(signed'(val));
      REG_CENTER_Y: sh_cy = longint'(signed'(val));
      REG_DESCENT:  sh_descent = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic configure(logic md, logic [19:0] per, logic [31:0] rad, logic [31:0] cx,
                           logic [31:0] cy, logic [31:0] dsc);
    write_reg(REG_MODE, {31'd0, md});
    write_reg(REG_PERIOD, {12'd0, per});
    write_reg(REG_RADIUS, rad);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_DESCENT, dsc);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Hold until every prediction is matched and the block has settled
  task automatic drain();
    while (tick_q.size() > 0 || in_valid || setpoint_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_tick(logic [19:0] dt, logic fresh, logic [31:0] z);
    tick_q.push_back('{dt, fresh, z});
  endtask

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  initial begin
    sh_mode = 1'b0; sh_period = '0;
    sh_radius = 0; sh_cx = 0; sh_cy = 0; sh_descent = 0;
    sh_elapsed = '0; sh_held_z = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: radius zero, short period falls back to default
    add_tick(20'd0, 1'b1, 32'h7fff_ffff);
    add_tick(20'hfffff, 1'b0, 32'h0);
    add_tick(20'd1, 1'b1, 32'h8000_0000);
    drain();

    // Circle, minimum period, extreme radius and centers; walk all quadrants
    configure(1'b0, 20'd1000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    for (int i = 0; i < 8; i++) add_tick(20'd125000, i[0], i[1] ? 32'h8000_0000 : 32'h1234);
    add_tick(20'd999, 1'b0, 32'h0);
    drain();

    // Spiral, long periods, negative radius, extreme descents
    configure(1'b1, 20'd1000000, 32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff);
    add_tick(20'hfffff, 1'b1, 32'h5555_aaaa);
    add_tick(20'hfffff, 1'b0, 32'haaaa_5555);
    drain();
    configure(1'b1, 20'hfffff, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    add_tick(20'h55555, 1'b1, 32'hffff_ffff);
    add_tick(20'haaaaa, 1'b0, 32'h0);
    drain();
    configure(1'b0, 20'd999, 32'h0005_0000, 32'h0, 32'h0, 32'h0);
    add_tick(20'd10000, 1'b0, 32'h0);
    drain();

    // Random phases; the last one runs without idling
    for (int ph = 0; ph < 10; ph++) begin
      configure(1'($urandom_range(0, 1)),
                20'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1100)
                    : $urandom_range(1000, 1048575)),
                pick_len(), pick_len(), pick_len(), pick_len());
      if (ph == 9) quiet = 1'b1;
      for (int i = 0; i < 50; i++)
        add_tick(($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 20000)),
                 1'($urandom_range(0, 1)), $urandom);
      drain();
    end

    if (errors == 0) begin
      $display("PASS circle_spiral_setpoint_generator");
    end else begin
      $display("FAIL circle_spiral_setpoint_generator");
    end
    $finish;
  end

endmodule
